// ----- hdl/detection_box_nms_filter_unit_defines.svh -----
// Assertion macros for the detection box NMS filter.
// Used by the top level only; compiled out when SYNTH is defined.
`ifndef DETECTION_BOX_NMS_FILTER_UNIT_DEFINES_SVH
`define DETECTION_BOX_NMS_FILTER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define DBNMS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dbnms check failed");
`define DBNMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dbnms check failed");
`else
`define DBNMS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define DBNMS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/dbnms_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants for the detection box NMS filter.
// No dependencies; imported by the coordinate mapper and the top level.
package dbnms_pkg;

  localparam int SCORE_W    = 16;
  localparam int CORNER_W   = 16;
  localparam int BOX_W      = 4 * CORNER_W;
  localparam int COORD_FRAC = 4;   // Q12.4 corners
  localparam int PAD_W      = 12;
  localparam int LIMIT_W    = 13;
  localparam int SCALE_W    = 16;
  localparam int SCALE_FRAC = 12;  // Q4.12 scale
  localparam int PIX_W      = CORNER_W - 1 - COORD_FRAC;  // positive pixel part
  localparam int NUM_W      = PIX_W + SCALE_FRAC;
  localparam int RES_W      = 16;

  // Visibility: score * 10 >= 65536
  localparam int VIS_NUM = 10;
  localparam int VIS_DEN = 65536;
  localparam int VIS_W   = 20;

  // Register indexes
  localparam logic [2:0] REG_SCORE_THR = 3'd0;
  localparam logic [2:0] REG_IOU_THR   = 3'd1;
  localparam logic [2:0] REG_PAD_LEFT  = 3'd2;
  localparam logic [2:0] REG_PAD_TOP   = 3'd3;
  localparam logic [2:0] REG_MODEL_W   = 3'd4;
  localparam logic [2:0] REG_MODEL_H   = 3'd5;
  localparam logic [2:0] REG_SCALE_X   = 3'd6;
  localparam logic [2:0] REG_SCALE_Y   = 3'd7;

endpackage

// ----- hdl/detection_box_nms_filter_unit.sv -----
`timescale 1ns / 1ps
// Channel  | dir | handshake            | content
// in_      | in  | tvalid/tready/tlast  | candidate word, tlast ends the frame
// out_     | out | tvalid/tready/tlast  | detection word, tuser flags
// cfg_     | in  | APB psel/penable     | eight threshold/mapping registers
// Collection takes one word per cycle. On the last word the block runs rounds:
// each round is one pass over the stored set (through the single read port of the
// candidate memory, the five-stage overlap pipeline and a decision state) plus a
// coordinate division per kept box, after a push state when a held word waits to go out;
// at most MAX_DETECTIONS rounds.
// Reset is synchronous; memories hold no reset and need no clearing pass.
// A stalled out_tready holds the push and the final word; in_tready is low while processing.
// Depends on dbnms_pkg, dbnms_coord_map and the defines header.
`include "detection_box_nms_filter_unit_defines.svh"
module detection_box_nms_filter_unit
  import dbnms_pkg::*;
#(
  parameter int MAX_CANDIDATES = 1024,
  parameter int MAX_DETECTIONS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // score, box_x_min, box_y_min, box_x_max, box_y_max
  input  logic        in_tlast,   // last_candidate
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // det_left, det_top, det_right, det_bottom, det_score
  output logic [1:0]  out_tuser,  // no_detection, overflowed
  output logic        out_tlast,  // last_result
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int IDX_W = $clog2(MAX_CANDIDATES);
  localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);
  localparam int DET_W = $clog2(MAX_DETECTIONS + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DECIDE, ST_PUSH, ST_MAP, ST_FINAL
  } state_t;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [SCORE_W-1:0] score;
    logic [BOX_W-1:0]   box;
    logic               done;
  } meta_t;

  // configuration
  logic [15:0] score_thr_r, iou_thr_r, scale_x_r, scale_y_r;
  logic [PAD_W-1:0]   pad_left_r, pad_top_r;
  logic [LIMIT_W-1:0] model_w_r, model_h_r;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_thr_r <= 16'd32768;
      iou_thr_r   <= 16'd32768;
      pad_left_r  <= '0;
      pad_top_r   <= '0;
      model_w_r   <= LIMIT_W'(640);
      model_h_r   <= LIMIT_W'(640);
      scale_x_r   <= 16'd4096;
      scale_y_r   <= 16'd4096;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        REG_SCORE_THR: score_thr_r <= cfg_pwdata[15:0];
        REG_IOU_THR:   iou_thr_r   <= cfg_pwdata[15:0];
        REG_PAD_LEFT:  pad_left_r  <= cfg_pwdata[PAD_W-1:0];
        REG_PAD_TOP:   pad_top_r   <= cfg_pwdata[PAD_W-1:0];
        REG_MODEL_W:   model_w_r   <= cfg_pwdata[LIMIT_W-1:0];
        REG_MODEL_H:   model_h_r   <= cfg_pwdata[LIMIT_W-1:0];
        REG_SCALE_X:   scale_x_r   <= cfg_pwdata[15:0];
        REG_SCALE_Y:   scale_y_r   <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      REG_SCORE_THR: cfg_prdata = 32'(score_thr_r);
      REG_IOU_THR:   cfg_prdata = 32'(iou_thr_r);
      REG_PAD_LEFT:  cfg_prdata = 32'(pad_left_r);
      REG_PAD_TOP:   cfg_prdata = 32'(pad_top_r);
      REG_MODEL_W:   cfg_prdata = 32'(model_w_r);
      REG_MODEL_H:   cfg_prdata = 32'(model_h_r);
      REG_SCALE_X:   cfg_prdata = 32'(scale_x_r);
      REG_SCALE_Y:   cfg_prdata = 32'(scale_y_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // control state
  state_t             state_r;
  logic [CNT_W-1:0]   cand_count_r, cand_count_nxt, iss_r;
  logic               ovf_r, have_win_r, best_v_r, hold_v_r, round0_r, map_start_r;
  logic [DET_W-1:0]   det_cnt_r;
  logic [IDX_W-1:0]   win_idx_r, best_idx_r;
  logic [SCORE_W-1:0] win_score_r, best_score_r, hold_score_r;
  logic [BOX_W-1:0]   win_box_r, best_box_r;
  logic [RES_W-1:0]   hold_l_r, hold_t_r, hold_r_r, hold_b_r;

  logic in_acc, store_en, issuing, pipe_busy, out_free, visible, map_done, new_done;
  logic [SCORE_W-1:0] in_score;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign in_score  = in_tdata[15:0];
  assign store_en  = in_acc && (in_score > score_thr_r) &&
                     (cand_count_r < CNT_W'(MAX_CANDIDATES));
  assign cand_count_nxt = store_en ? cand_count_r + 1'b1 : cand_count_r;
  assign issuing   = (state_r == ST_SCAN) && (iss_r < cand_count_r);
  assign out_free  = !out_tvalid || out_tready;
  assign visible   = best_v_r &&
                     (VIS_W'(best_score_r) * VIS_W'(VIS_NUM) >= VIS_W'(VIS_DEN));

  // candidate and suppression memories
  logic [SCORE_W+BOX_W-1:0] cand_mem [MAX_CANDIDATES];
  logic                     flag_mem [MAX_CANDIDATES];
  logic [SCORE_W+BOX_W-1:0] rd_data_r;
  logic                     rd_flag_r, rd_v_r;
  logic [IDX_W-1:0]         rd_idx_r;

  meta_t s2_m_r, s3_m_r, s4_m_r, s5_m_r, rd_m;
  logic  s2_v_r, s3_v_r, s4_v_r, s5_v_r;

  always_ff @(posedge clk) begin
    if (store_en) cand_mem[cand_count_r[IDX_W-1:0]] <= {in_score, in_tdata[79:16]};
    rd_data_r <= cand_mem[iss_r[IDX_W-1:0]];
    if (s5_v_r) flag_mem[s5_m_r.idx] <= new_done;
    rd_flag_r <= flag_mem[iss_r[IDX_W-1:0]];
  end

  // overlap pipeline
  logic signed [CORNER_W-1:0] wx0, wy0, wx1, wy1, bx0, by0, bx1, by1;
  logic signed [17:0] w_raw, h_raw, ex, ey, wex, wey;
  logic [16:0]        w_cl, h_cl;
  logic [16:0]        s2_w_r, s2_h_r;
  logic signed [17:0] s2_ex_r, s2_ey_r;
  logic [33:0]        s3_inter_r, s4_inter_r, s5_inter_r;
  logic signed [35:0] s3_area_r, win_area_r;
  logic signed [37:0] s4_uni_r;
  logic signed [54:0] s5_prod_r;
  logic               s5_pos_r, is_win, ovl;

  always_comb begin
    rd_m.idx   = rd_idx_r;
    rd_m.score = rd_data_r[SCORE_W+BOX_W-1:BOX_W];
    rd_m.box   = rd_data_r[BOX_W-1:0];
    rd_m.done  = round0_r ? 1'b0 : rd_flag_r;   // flags hold stale data in round 0
    wx0 = win_box_r[15:0];
    wy0 = win_box_r[31:16];
    wx1 = win_box_r[47:32];
    wy1 = win_box_r[63:48];
    bx0 = rd_m.box[15:0];
    by0 = rd_m.box[31:16];
    bx1 = rd_m.box[47:32];
    by1 = rd_m.box[63:48];
    w_raw = 18'((wx1 < bx1) ? wx1 : bx1) - 18'((wx0 > bx0) ? wx0 : bx0) + 18'sd16;
    h_raw = 18'((wy1 < by1) ? wy1 : by1) - 18'((wy0 > by0) ? wy0 : by0) + 18'sd16;
    w_cl  = (w_raw < 0) ? '0 : w_raw[16:0];
    h_cl  = (h_raw < 0) ? '0 : h_raw[16:0];
    ex    = 18'(bx1) - 18'(bx0) + 18'sd16;
    ey    = 18'(by1) - 18'(by0) + 18'sd16;
    wex   = 18'(wx1) - 18'(wx0) + 18'sd16;
    wey   = 18'(wy1) - 18'(wy0) + 18'sd16;
    is_win   = have_win_r && (s5_m_r.idx == win_idx_r);
    ovl      = have_win_r && s5_pos_r &&
               ($signed({1'b0, s5_inter_r, 16'h0000}) > s5_prod_r);
    new_done = s5_m_r.done | is_win | ovl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      rd_v_r <= issuing;
      s2_v_r <= rd_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
    end
    rd_idx_r   <= iss_r[IDX_W-1:0];
    win_area_r <= wex * wey;
    s2_m_r     <= rd_m;
    s2_w_r     <= w_cl;
    s2_h_r     <= h_cl;
    s2_ex_r    <= ex;
    s2_ey_r    <= ey;
    s3_m_r     <= s2_m_r;
    s3_inter_r <= s2_w_r * s2_h_r;
    s3_area_r  <= s2_ex_r * s2_ey_r;
    s4_m_r     <= s3_m_r;
    s4_inter_r <= s3_inter_r;
    s4_uni_r   <= 38'(win_area_r) + 38'(s3_area_r) - $signed({4'b0000, s3_inter_r});
    s5_m_r     <= s4_m_r;
    s5_inter_r <= s4_inter_r;
    s5_pos_r   <= (s4_uni_r > 0);
    s5_prod_r  <= $signed({1'b0, iou_thr_r}) * s4_uni_r;
  end

  assign pipe_busy = rd_v_r | s2_v_r | s3_v_r | s4_v_r | s5_v_r;

  // coordinate mapping
  logic [3:0]       map_dn;
  logic [RES_W-1:0] map_l, map_t, map_r, map_b;

  dbnms_coord_map u_map_left (
    .clk, .rst_n, .start_i(map_start_r), .corner_i(win_box_r[15:0]),
    .pad_i(pad_left_r), .limit_i(model_w_r), .scale_i(scale_x_r),
    .done_o(map_dn[0]), .result_o(map_l));
  dbnms_coord_map u_map_top (
    .clk, .rst_n, .start_i(map_start_r), .corner_i(win_box_r[31:16]),
    .pad_i(pad_top_r), .limit_i(model_h_r), .scale_i(scale_y_r),
    .done_o(map_dn[1]), .result_o(map_t));
  dbnms_coord_map u_map_right (
    .clk, .rst_n, .start_i(map_start_r), .corner_i(win_box_r[47:32]),
    .pad_i(pad_left_r), .limit_i(model_w_r), .scale_i(scale_x_r),
    .done_o(map_dn[2]), .result_o(map_r));
  dbnms_coord_map u_map_bottom (
    .clk, .rst_n, .start_i(map_start_r), .corner_i(win_box_r[63:48]),
    .pad_i(pad_top_r), .limit_i(model_h_r), .scale_i(scale_y_r),
    .done_o(map_dn[3]), .result_o(map_b));

  assign map_done = &map_dn;

  // output word register
  logic             out_v_r, out_nodet_r, out_ovf_r, out_last_r;
  logic [RES_W-1:0] out_l_r, out_t_r, out_r_r, out_b_r, out_s_r;

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_s_r, out_b_r, out_r_r, out_t_r, out_l_r};
  assign out_tuser  = {out_ovf_r, out_nodet_r};
  assign out_tlast  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cand_count_r <= '0;
      ovf_r        <= 1'b0;
      out_v_r      <= 1'b0;
      hold_v_r     <= 1'b0;
      have_win_r   <= 1'b0;
      best_v_r     <= 1'b0;
      map_start_r  <= 1'b0;
      iss_r        <= '0;
      round0_r     <= 1'b0;
      det_cnt_r    <= '0;
    end else begin
      map_start_r <= 1'b0;
      if (out_v_r && out_tready) out_v_r <= 1'b0;
      if (issuing) iss_r <= iss_r + 1'b1;
      // keep the first of equal scores: entries arrive in index order
      if (s5_v_r && !new_done && (!best_v_r || s5_m_r.score > best_score_r)) begin
        best_v_r     <= 1'b1;
        best_score_r <= s5_m_r.score;
        best_box_r   <= s5_m_r.box;
        best_idx_r   <= s5_m_r.idx;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            cand_count_r <= cand_count_nxt;
            if (in_score > score_thr_r && cand_count_r >= CNT_W'(MAX_CANDIDATES))
              ovf_r <= 1'b1;
            if (in_tlast) begin
              hold_v_r   <= 1'b0;
              have_win_r <= 1'b0;
              det_cnt_r  <= '0;
              iss_r      <= '0;
              best_v_r   <= 1'b0;
              round0_r   <= 1'b1;
              state_r    <= (cand_count_nxt == '0) ? ST_FINAL : ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (!issuing && !pipe_busy) state_r <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (visible) begin
            win_box_r   <= best_box_r;
            win_idx_r   <= best_idx_r;
            win_score_r <= best_score_r;
            have_win_r  <= 1'b1;
            if (hold_v_r) begin
              state_r <= ST_PUSH;
            end else begin
              state_r     <= ST_MAP;
              map_start_r <= 1'b1;
            end
          end else begin
            state_r <= ST_FINAL;
          end
        end
        ST_PUSH: begin
          if (out_free) begin
            out_v_r     <= 1'b1;
            out_l_r     <= hold_l_r;
            out_t_r     <= hold_t_r;
            out_r_r     <= hold_r_r;
            out_b_r     <= hold_b_r;
            out_s_r     <= hold_score_r;
            out_nodet_r <= 1'b0;
            out_ovf_r   <= ovf_r;
            out_last_r  <= 1'b0;
            hold_v_r    <= 1'b0;
            state_r     <= ST_MAP;
            map_start_r <= 1'b1;
          end
        end
        ST_MAP: begin
          if (map_done) begin
            hold_l_r     <= map_l;
            hold_t_r     <= map_t;
            hold_r_r     <= map_r;
            hold_b_r     <= map_b;
            hold_score_r <= win_score_r;
            hold_v_r     <= 1'b1;
            det_cnt_r    <= det_cnt_r + 1'b1;
            if (det_cnt_r == DET_W'(MAX_DETECTIONS - 1)) begin
              state_r <= ST_FINAL;
            end else begin
              state_r  <= ST_SCAN;
              iss_r    <= '0;
              best_v_r <= 1'b0;
              round0_r <= 1'b0;
            end
          end
        end
        ST_FINAL: begin
          if (out_free) begin
            out_v_r      <= 1'b1;
            out_l_r      <= hold_v_r ? hold_l_r : '0;
            out_t_r      <= hold_v_r ? hold_t_r : '0;
            out_r_r      <= hold_v_r ? hold_r_r : '0;
            out_b_r      <= hold_v_r ? hold_b_r : '0;
            out_s_r      <= hold_v_r ? hold_score_r : '0;
            out_nodet_r  <= !hold_v_r;
            out_ovf_r    <= ovf_r;
            out_last_r   <= 1'b1;
            hold_v_r     <= 1'b0;
            cand_count_r <= '0;
            ovf_r        <= 1'b0;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `DBNMS_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, cand_count_r <= CNT_W'(MAX_CANDIDATES))
  `DBNMS_ASSERT_NOW(a_det_bound, clk, rst_n, 1'b1, det_cnt_r <= DET_W'(MAX_DETECTIONS))
  `DBNMS_ASSERT_NOW(a_pipe_in_scan, clk, rst_n, s5_v_r, state_r == ST_SCAN)
  `DBNMS_ASSERT_NEXT(a_map_start, clk, rst_n, map_start_r, state_r == ST_MAP)

endmodule

// ----- hdl/dbnms_coord_map.sv -----
`timescale 1ns / 1ps
// Maps one Q12.4 corner to an output pixel: pad, truncate, clamp, divide by scale.
// Restoring divider, one quotient bit per cycle. Depends on dbnms_pkg.
module dbnms_coord_map
  import dbnms_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start_i,
  input  logic signed [CORNER_W-1:0] corner_i,
  input  logic [PAD_W-1:0]           pad_i,
  input  logic [LIMIT_W-1:0]         limit_i,
  input  logic [SCALE_W-1:0]         scale_i,
  output logic                       done_o,
  output logic [RES_W-1:0]           result_o
);

  localparam int D_W   = CORNER_W + 2;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic signed [D_W-1:0] d;
  logic [PIX_W-1:0]      pix;
  logic [NUM_W-1:0]      num_r;
  logic [NUM_W-1:0]      q_r;
  logic [SCALE_W:0]      rem_r;
  logic [SCALE_W:0]      rem_sh;
  logic                  qbit;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;

  always_comb begin
    d   = D_W'(corner_i) - $signed({2'b00, pad_i, {COORD_FRAC{1'b0}}});
    pix = '0;
    if (d > 0) pix = d[COORD_FRAC +: PIX_W];
    if (LIMIT_W'(pix) > limit_i) pix = limit_i[PIX_W-1:0];
    rem_sh = {rem_r[SCALE_W-1:0], num_r[NUM_W-1]};
    qbit   = (rem_sh >= {1'b0, scale_i});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_o <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
        num_r  <= {pix, {SCALE_FRAC{1'b0}}};
        rem_r  <= '0;
        q_r    <= '0;
      end else if (busy_r) begin
        rem_r <= qbit ? rem_sh - {1'b0, scale_i} : rem_sh;
        num_r <= {num_r[NUM_W-2:0], 1'b0};
        q_r   <= {q_r[NUM_W-2:0], qbit};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  // saturate; a zero scale yields all ones and lands here too
  assign result_o = (|q_r[NUM_W-1:RES_W]) ? {RES_W{1'b1}} : q_r[RES_W-1:0];

endmodule
